@@ rtl/joystick_deadzone_smoother_core_assert.svh @@
// assertion macros shared by the joystick conditioning rtl
`ifndef JOYSTICK_DEADZONE_SMOOTHER_CORE_ASSERT_SVH
`define JOYSTICK_DEADZONE_SMOOTHER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define JDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define JDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jds_pkg.sv @@
// shared types and constants for the joystick conditioning block
package jds_pkg;

    // register reset values
    localparam logic [14:0] DZ_LEVEL_RST = 15'd4588;
    localparam logic [15:0] DZ_GAIN_RST  = 16'd4763;
    localparam logic [14:0] SMOOTH_RST   = 15'd10486;
    localparam logic [14:0] SNAP_RST     = 15'd983;
    localparam logic [14:0] BRAKE_RST    = 15'd21299;

    // register indexes on the configuration channel
    typedef enum logic [2:0] {
        CFG_DZ_LEVEL = 3'd0,
        CFG_DZ_GAIN  = 3'd1,
        CFG_SMOOTH   = 3'd2,
        CFG_SNAP     = 3'd3,
        CFG_BRAKE    = 3'd4
    } t_cfg_idx;

    // step enables from the sequencer to the axis lanes
    typedef struct packed {
        logic load;
        logic diff;
        logic step;
        logic avg;
    } t_lane_ctl;

endpackage

@@ rtl/jds_in_if.sv @@
// sample channel: valid, ready and a two-axis joystick sample
interface jds_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;

    modport source (output valid, output x_sample, output y_sample, input ready);
    modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

@@ rtl/jds_out_if.sv @@
// result channel: valid, ready and the conditioned axes with flags
interface jds_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               throttle_on;
    logic               brake_on;

    modport source (output valid, output move_x, output move_y, output throttle_on,
                    output brake_on, input ready);
    modport sink   (input valid, input move_x, input move_y, input throttle_on,
                    input brake_on, output ready);
endinterface

@@ rtl/jds_cfg_if.sv @@
// configuration write channel: valid, ready, register index and data
interface jds_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [15:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/jds_lane.sv @@
// one axis lane: deadzone rescale, moving average, snap and output rounding
`include "joystick_deadzone_smoother_core_assert.svh"

module jds_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jds_pkg::t_lane_ctl i_ctl,
    input  logic signed [15:0] i_sample,
    input  logic [14:0]        i_dz_level,
    input  logic [15:0]        i_dz_gain,
    input  logic [14:0]        i_smooth,
    input  logic [14:0]        i_snap,
    output logic signed [15:0] o_move
);

    logic               r_neg;
    logic [31:0]        r_prod;
    logic signed [20:0] r_diff;
    logic signed [36:0] r_wprod;
    logic signed [19:0] r_avg;
    logic signed [15:0] r_move;

    logic               w_neg;
    logic [15:0]        w_mag;
    logic [15:0]        w_level16;
    logic               w_outside;
    logic [15:0]        w_excess;
    logic [32:0]        w_round;
    logic [20:0]        w_scaled;
    logic [14:0]        w_mag15;
    logic signed [15:0] w_shaped;
    logic signed [20:0] w_target;
    logic signed [20:0] w_avg_ext;
    logic signed [20:0] w_diff;
    logic signed [37:0] w_rnd;
    logic signed [22:0] w_step;
    logic signed [23:0] w_sum;
    logic signed [19:0] w_clamped;
    logic signed [20:0] w_clamped_ext;
    logic signed [20:0] w_band;
    logic               w_in_band;
    logic signed [19:0] w_avg_next;
    logic signed [20:0] w_mrnd;
    logic signed [16:0] w_mq;
    logic signed [15:0] w_move;

    // magnitude against the deadzone
    always_comb begin
        w_neg     = i_sample[15];
        w_mag     = w_neg ? $unsigned(-i_sample) : $unsigned(i_sample);
        w_level16 = {1'b0, i_dz_level};
        w_outside = (w_mag >= w_level16);
        w_excess  = w_mag - w_level16;
    end

    // rescaled value, sign restored, minus the running average
    always_comb begin
        w_round   = {1'b0, r_prod} + 33'd2048;
        w_scaled  = w_round[32:12];
        w_mag15   = (w_scaled > 21'd32767) ? 15'h7FFF : w_scaled[14:0];
        w_shaped  = r_neg ? -$signed({1'b0, w_mag15}) : $signed({1'b0, w_mag15});
        w_target  = {w_shaped[15], w_shaped, 4'b0000};
        w_avg_ext = {r_avg[19], r_avg};
        w_diff    = w_target - w_avg_ext;
    end

    // rounded step, saturation and snap to zero
    always_comb begin
        w_rnd         = {r_wprod[36], r_wprod} + 38'sd16384;
        w_step        = w_rnd[37:15];
        w_sum         = {{4{r_avg[19]}}, r_avg} + {w_step[22], w_step};
        if (w_sum > 24'sd524287) begin
            w_clamped = 20'sh7FFFF;
        end else if (w_sum < -24'sd524288) begin
            w_clamped = 20'sh80000;
        end else begin
            w_clamped = w_sum[19:0];
        end
        w_clamped_ext = {w_clamped[19], w_clamped};
        w_band        = $signed({2'b00, i_snap, 4'b0000});
        w_in_band     = (w_clamped_ext > -w_band) && (w_clamped_ext < w_band);
        w_avg_next    = w_in_band ? 20'sd0 : w_clamped;
    end

    // back to q1.15 with half-up rounding
    always_comb begin
        w_mrnd = {w_avg_next[19], w_avg_next} + 21'sd8;
        w_mq   = w_mrnd[20:4];
        if (w_mq > 17'sd32767) begin
            w_move = 16'sd32767;
        end else if (w_mq < -17'sd32767) begin
            w_move = -16'sd32767;
        end else begin
            w_move = w_mq[15:0];
        end
    end

    // datapath registers, one step enable each
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg  <= w_neg;
            r_prod <= w_outside ? (w_excess * i_dz_gain) : 32'd0;
        end
        if (i_ctl.diff) begin
            r_diff <= w_diff;
        end
        if (i_ctl.step) begin
            r_wprod <= r_diff * $signed({1'b0, i_smooth});
        end
        if (i_ctl.avg) begin
            r_move <= w_move;
        end
    end

    // running average state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (i_ctl.avg) begin
            r_avg <= w_avg_next;
        end
    end

    assign o_move = r_move;

    // a freshly stored average never sits strictly inside the snap band
    `JDS_ASSERT_NEXT(a_snap_band, i_ctl.avg, (w_avg_ext == 21'sd0) || (w_avg_ext >= $past(w_band)) || (w_avg_ext <= -$past(w_band)), "average left inside snap band")

endmodule

@@ rtl/jds_merge.sv @@
// merge stage: combines both lanes into flags and holds the result register
module jds_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    input  logic [14:0]        i_brake_level,
    output logic               o_free,
    jds_out_if.source          o_out
);

    logic               r_valid;
    logic signed [15:0] r_move_x;
    logic signed [15:0] r_move_y;
    logic               r_throttle;
    logic               r_brake;

    logic               w_throttle;
    logic               w_brake;

    // flags from the conditioned axes
    always_comb begin
        w_throttle = (i_move_x != 16'sd0) || (i_move_y != 16'sd0);
        w_brake    = (i_move_y > $signed({1'b0, i_brake_level}));
    end

    // result slot is free when empty or being taken this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_move_x   <= i_move_x;
            r_move_y   <= i_move_y;
            r_throttle <= w_throttle;
            r_brake    <= w_brake;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.move_x      = r_move_x;
    assign o_out.move_y      = r_move_y;
    assign o_out.throttle_on = r_throttle;
    assign o_out.brake_on    = r_brake;

endmodule

@@ rtl/joystick_deadzone_smoother_core.sv @@
// top level: configuration registers, step sequencer, two axis lanes and merge
//
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    x_sample, y_sample (q1.15)
//  o_out     out   valid/ready    move_x, move_y, throttle_on, brake_on
//  i_cfg     in    valid/ready    reg_index, wr_data (ready always high)
//
// one sample at a time: the lanes run scale multiply, difference,
// weight multiply and average update in turn, and the next sample needs the
// average that the last step writes back.
// the result waits in the merge register; a new sample is taken while it waits,
// and the sequencer holds in its merge step only when that register is still full.
// synchronous active-low reset clears both averages and loads register defaults.
`include "joystick_deadzone_smoother_core_assert.svh"

module joystick_deadzone_smoother_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jds_in_if.sink    i_in,
    jds_out_if.source o_out,
    jds_cfg_if.sink   i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIFF  = 5'b00010,
        S_STEP  = 5'b00100,
        S_AVG   = 5'b01000,
        S_MERGE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [14:0] r_dz_level;
    logic [15:0] r_dz_gain;
    logic [14:0] r_smooth;
    logic [14:0] r_snap;
    logic [14:0] r_brake;

    logic               w_accept;
    logic               w_out_free;
    logic               w_merge_load;
    logic signed [15:0] w_y_neg;
    logic signed [15:0] w_move_x;
    logic signed [15:0] w_move_y;
    jds_pkg::t_lane_ctl w_ctl;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_level <= jds_pkg::DZ_LEVEL_RST;
            r_dz_gain  <= jds_pkg::DZ_GAIN_RST;
            r_smooth   <= jds_pkg::SMOOTH_RST;
            r_snap     <= jds_pkg::SNAP_RST;
            r_brake    <= jds_pkg::BRAKE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                jds_pkg::CFG_DZ_LEVEL: r_dz_level <= i_cfg.wr_data[14:0];
                jds_pkg::CFG_DZ_GAIN:  r_dz_gain  <= i_cfg.wr_data;
                jds_pkg::CFG_SMOOTH:   r_smooth   <= i_cfg.wr_data[14:0];
                jds_pkg::CFG_SNAP:     r_snap     <= i_cfg.wr_data[14:0];
                jds_pkg::CFG_BRAKE:    r_brake    <= i_cfg.wr_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // input handshake and merge load
    assign i_in.ready   = (r_state == S_IDLE) || ((r_state == S_MERGE) && w_out_free);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_merge_load = (r_state == S_MERGE) && w_out_free;

    // y axis inverted, minus one saturates to plus one
    assign w_y_neg = (i_in.y_sample == 16'sh8000) ? 16'sd32767 : -i_in.y_sample;

    // step sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_DIFF;
            S_DIFF:  n_state = S_STEP;
            S_STEP:  n_state = S_AVG;
            S_AVG:   n_state = S_MERGE;
            S_MERGE: begin
                if (w_out_free) begin
                    n_state = w_accept ? S_DIFF : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_ctl.load = w_accept;
        w_ctl.diff = (r_state == S_DIFF);
        w_ctl.step = (r_state == S_STEP);
        w_ctl.avg  = (r_state == S_AVG);
    end

    // axis lanes
    jds_lane u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (i_in.x_sample),
        .i_dz_level (r_dz_level),
        .i_dz_gain  (r_dz_gain),
        .i_smooth   (r_smooth),
        .i_snap     (r_snap),
        .o_move     (w_move_x)
    );

    jds_lane u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (w_y_neg),
        .i_dz_level (r_dz_level),
        .i_dz_gain  (r_dz_gain),
        .i_smooth   (r_smooth),
        .i_snap     (r_snap),
        .o_move     (w_move_y)
    );

    // merge and result register
    jds_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_merge_load),
        .i_move_x      (w_move_x),
        .i_move_y      (w_move_y),
        .i_brake_level (r_brake),
        .o_free        (w_out_free),
        .o_out         (o_out)
    );

    // an accepted sample always starts the lane sequence next cycle
    `JDS_ASSERT_NEXT(a_accept_starts, w_accept, r_state == S_DIFF, "accepted sample did not start lanes")

    // the average update is always followed by the merge step
    `JDS_ASSERT_NEXT(a_avg_to_merge, r_state == S_AVG, r_state == S_MERGE, "average update not followed by merge")

    // a blocked result keeps the sequencer in its merge step
    `JDS_ASSERT_NEXT(a_merge_hold, (r_state == S_MERGE) && o_out.valid && !o_out.ready, r_state == S_MERGE, "merge step left while result blocked")

endmodule

@@ tb/joystick_deadzone_smoother_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the joystick deadzone and smoothing core
module joystick_deadzone_smoother_core_tb;

    // unused register slots, writes there must change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int     RUN_LIMIT    = 200000;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 100;
    localparam int     DRAIN_CYCLES = 24;
    localparam longint AVG_TOP      = 524287;
    localparam longint AVG_BOT      = -524288;

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic               thr;
        logic               brk;
    } t_move;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    typedef enum logic [1:0] {PICK_ZERO, PICK_TOP, PICK_RESET, PICK_RAND} t_pick;

    typedef struct {
        t_row_kind          kind;
        logic [2:0]         idx;
        logic [15:0]        data;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        t_move              want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    jds_in_if  smp_if ();
    jds_out_if res_if ();
    jds_cfg_if cfg_if ();

    joystick_deadzone_smoother_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // predictor copy of the registers and the two averages
    logic [14:0]        dz_level;
    logic [15:0]        dz_gain;
    logic [14:0]        sm_weight;
    logic [14:0]        snap_lvl;
    logic [14:0]        brake_lvl;
    logic signed [19:0] ema_x;
    logic signed [19:0] ema_y;

    t_move    pending_moves[$];
    t_dir_row dir_rows[];

    int mismatches = 0;
    int cycles     = 0;
    int gap_pct    = 25;
    int stall_pct  = 25;
    bit quiet      = 1'b0;
    bit smp_held   = 1'b0;
    bit cfg_held   = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // deadzone, rescale and clamp of one axis
    function automatic int deadzone_axis(input int v);
        longint mag, lvl, gain, s;
        lvl = dz_level;
        gain = dz_gain;
        mag = (v < 0) ? -v : v;
        if (mag < lvl) return 0;
        s = ((mag - lvl) * gain + 2048) >>> 12;
        if (s > 32767) s = 32767;
        return (v < 0) ? -int'(s) : int'(s);
    endfunction

    // moving average with snap band, returns the rounded output
    function automatic int ema_axis(inout logic signed [19:0] acc, input int r);
        longint prev, w, band, a, m;
        prev = acc;
        w = sm_weight;
        band = snap_lvl;
        band = band * 16;
        a = prev + ((((longint'(r) * 16) - prev) * w + 16384) >>> 15);
        if (a > AVG_TOP) a = AVG_TOP;
        if (a < AVG_BOT) a = AVG_BOT;
        if (a > -band && a < band) a = 0;
        acc = 20'(a);
        m = (a + 8) >>> 4;
        if (m > 32767) m = 32767;
        if (m < -32767) m = -32767;
        return int'(m);
    endfunction

    function automatic t_move predict_move(input logic signed [15:0] x,
                                           input logic signed [15:0] y);
        t_move m;
        int    yn, bl;
        yn = -int'(y);
        if (yn > 32767) yn = 32767;
        bl = brake_lvl;
        m.mx = 16'(ema_axis(ema_x, deadzone_axis(int'(x))));
        m.my = 16'(ema_axis(ema_y, deadzone_axis(yn)));
        m.thr = (m.mx != 0) || (m.my != 0);
        m.brk = (int'(m.my) > bl);
        return m;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            jds_pkg::CFG_DZ_LEVEL: dz_level = data[14:0];
            jds_pkg::CFG_DZ_GAIN:  dz_gain = data;
            jds_pkg::CFG_SMOOTH:   sm_weight = data[14:0];
            jds_pkg::CFG_SNAP:     snap_lvl = data[14:0];
            jds_pkg::CFG_BRAKE:    brake_lvl = data[14:0];
            default: ;
        endcase
    endfunction

    function automatic t_dir_row smp_row(input int x, input int y, input bit zero = 1'b0);
        t_dir_row r;
        r.kind = ROW_SAMPLE;
        r.idx = jds_pkg::CFG_DZ_LEVEL;
        r.data = '0;
        r.x = 16'(x);
        r.y = 16'(y);
        r.typed = zero;
        r.want = '0;
        return r;
    endfunction

    function automatic t_dir_row reg_row(input logic [2:0] idx, input logic [15:0] data);
        t_dir_row r;
        r = smp_row(0, 0);
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // register value for a phase; the spare top bit of narrow registers is random
    function automatic logic [15:0] pick_reg(input t_pick mode, input logic [15:0] top,
                                             input logic [15:0] dflt, input logic [15:0] rnd);
        logic [15:0] v;
        case (mode)
            PICK_ZERO:  v = '0;
            PICK_TOP:   v = top;
            PICK_RESET: v = dflt;
            default:    v = rnd;
        endcase
        if (top != 16'hFFFF) v[15] = 1'($urandom);
        return v;
    endfunction

    function automatic t_pick choose_pick(input int phase);
        int r;
        if (phase == 0) return PICK_TOP;
        if (phase == 1) return PICK_ZERO;
        r = $urandom_range(0, 9);
        if (r == 0) return PICK_ZERO;
        if (r == 1) return PICK_TOP;
        if (r < 5) return PICK_RESET;
        return PICK_RAND;
    endfunction

    // next axis value: held, near the deadzone, fully random or an extreme
    function automatic logic signed [15:0] next_axis(input logic signed [15:0] prev);
        int r, m, k;
        r = $urandom_range(0, 99);
        m = int'(dz_level) + 400;
        if (m > 32767) m = 32767;
        if (r < 35) return 16'($urandom);
        if (r < 55) return prev;
        if (r < 72) return 16'(int'($urandom_range(0, 2 * m)) - m);
        if (r < 85) begin
            k = int'(dz_level) + int'($urandom_range(0, 2)) - 1;
            return 16'($urandom_range(0, 1) ? k : -k);
        end
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sh7FFF;
        endcase
    endfunction

    task automatic drop_cfg_valid();
        if (cfg_held) begin
            cfg_if.valid <= 1'b0;
            cfg_held = 1'b0;
        end
    endtask

    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input bit typed, input t_move want);
        t_move guess;
        drop_cfg_valid();
        smp_if.valid <= 1'b1;
        smp_if.x_sample <= x;
        smp_if.y_sample <= y;
        smp_held = 1'b1;
        do @(posedge i_clk); while (!smp_if.ready);
        guess = predict_move(x, y);
        pending_moves.push_back(typed ? want : guess);
    endtask

    // random burst of idle cycles on the sample side
    task automatic maybe_gap();
        int n;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 6);
            smp_if.valid <= 1'b0;
            smp_held = 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // block idle: every expected result has come out
    task automatic wait_idle();
        if (smp_held) begin
            smp_if.valid <= 1'b0;
            smp_held = 1'b0;
        end
        while (pending_moves.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data <= data;
        cfg_held = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        store_reg(idx, data);
    endtask

    // result side back-pressure in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 5);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_move want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_moves.size() == 0) begin
                $display("%0t: result with none expected, move_x %0d move_y %0d",
                         $time, res_if.move_x, res_if.move_y);
                mismatches++;
            end else begin
                want = pending_moves.pop_front();
                if (res_if.move_x !== want.mx) begin
                    $display("%0t: move_x expected %0d actual %0d",
                             $time, want.mx, res_if.move_x);
                    mismatches++;
                end
                if (res_if.move_y !== want.my) begin
                    $display("%0t: move_y expected %0d actual %0d",
                             $time, want.my, res_if.move_y);
                    mismatches++;
                end
                if (res_if.throttle_on !== want.thr) begin
                    $display("%0t: throttle_on expected %0b actual %0b",
                             $time, want.thr, res_if.throttle_on);
                    mismatches++;
                end
                if (res_if.brake_on !== want.brk) begin
                    $display("%0t: brake_on expected %0b actual %0b",
                             $time, want.brk, res_if.brake_on);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic signed [15:0] sx, sy;
        i_rst_n <= 1'b0;
        smp_if.valid <= 1'b0;
        smp_if.x_sample <= '0;
        smp_if.y_sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.reg_index <= jds_pkg::CFG_DZ_LEVEL;
        cfg_if.wr_data <= '0;
        dz_level = jds_pkg::DZ_LEVEL_RST;
        dz_gain = jds_pkg::DZ_GAIN_RST;
        sm_weight = jds_pkg::SMOOTH_RST;
        snap_lvl = jds_pkg::SNAP_RST;
        brake_lvl = jds_pkg::BRAKE_RST;
        ema_x = '0;
        ema_y = '0;
        sx = '0;
        sy = '0;

        dir_rows = '{
            smp_row(0, 0, 1'b1),
            smp_row(4587, -4587, 1'b1),
            smp_row(-4587, 4587, 1'b1),
            smp_row(32767, 0),
            smp_row(32767, -32768),            // y at minus one saturates when negated
            smp_row(-32768, 32767),
            smp_row(-32768, -32768),
            smp_row(-32768, -32768),
            smp_row(-32768, -32768),
            smp_row(4588, -4588),              // right on the deadzone edge
            smp_row(0, 0),
            smp_row(-1, 1),
            reg_row(jds_pkg::CFG_DZ_GAIN, 16'h0000),    // zero gain
            smp_row(32767, -32768),
            reg_row(jds_pkg::CFG_DZ_LEVEL, 16'h8000),   // only the dropped top bit set
            reg_row(jds_pkg::CFG_DZ_GAIN, 16'h1000),
            smp_row(1, -1),
            smp_row(-32768, 32767),
            reg_row(jds_pkg::CFG_DZ_GAIN, 16'hFFFF),    // gain far above one saturates
            smp_row(100, -100),
            reg_row(jds_pkg::CFG_SMOOTH, 16'h7FFF),
            reg_row(jds_pkg::CFG_SNAP, 16'h0000),
            reg_row(jds_pkg::CFG_BRAKE, 16'h0000),
            smp_row(12345, -12345),
            smp_row(-200, 200),
            reg_row(jds_pkg::CFG_SMOOTH, 16'h0000),     // frozen average
            smp_row(32767, 32767),
            reg_row(jds_pkg::CFG_SNAP, 16'h7FFF),
            reg_row(jds_pkg::CFG_SMOOTH, 16'h4000),
            smp_row(20000, -20000),
            reg_row(CFG_SPARE_LO, 16'hFFFF),
            reg_row(CFG_SPARE_HI, 16'h5A5A),
            reg_row(jds_pkg::CFG_BRAKE, 16'hFFFF),
            smp_row(-20000, 20000)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].want);
                maybe_gap();
            end
        end

        // random phases, each under a fresh register setting
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            quiet = (p == PHASES - 1);
            gap_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
            stall_pct = quiet ? 0 : 20 * $urandom_range(0, 2);
            write_reg(jds_pkg::CFG_DZ_LEVEL,
                      pick_reg(choose_pick(p), 16'h7FFF, jds_pkg::DZ_LEVEL_RST,
                               16'($urandom_range(0, 12000))));
            write_reg(jds_pkg::CFG_DZ_GAIN,
                      pick_reg(choose_pick(p), 16'hFFFF, jds_pkg::DZ_GAIN_RST,
                               16'($urandom_range(1024, 16000))));
            write_reg(jds_pkg::CFG_SMOOTH,
                      pick_reg(choose_pick(p), 16'h7FFF, jds_pkg::SMOOTH_RST,
                               16'($urandom_range(0, 32767))));
            write_reg(jds_pkg::CFG_SNAP,
                      pick_reg(choose_pick(p), 16'h7FFF, jds_pkg::SNAP_RST,
                               16'($urandom_range(0, 3000))));
            write_reg(jds_pkg::CFG_BRAKE,
                      pick_reg(choose_pick(p), 16'h7FFF, jds_pkg::BRAKE_RST,
                               16'($urandom_range(0, 32767))));
            if ($urandom_range(0, 1) != 0)
                write_reg(3'(CFG_SPARE_LO + $urandom_range(0, 2)), 16'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sx = next_axis(sx);
                sy = next_axis(sy);
                send_sample(sx, sy, 1'b0, '0);
                maybe_gap();
            end
        end

        // drain and report
        wait_idle();
        drop_cfg_valid();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
